// ===== hdl/lbbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU block buffer cache package
// Shared transaction types and operation codes.
// ----------------------------------------------------------------------------
package lbbc_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned UnitW  = 5;
  localparam int unsigned BlockW = 32;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned MaskW  = 16;
  localparam int unsigned KindW  = 2;

  localparam logic [OpW-1:0] OpLookup     = 3'd0;
  localparam logic [OpW-1:0] OpMarkDirty  = 3'd1;
  localparam logic [OpW-1:0] OpInvalidate = 3'd2;
  localparam logic [OpW-1:0] OpFlushUnit  = 3'd3;
  localparam logic [OpW-1:0] OpFlushAll   = 3'd4;

  localparam logic [KindW-1:0] KindWriteback = 2'd0;
  localparam logic [KindW-1:0] KindRead      = 2'd1;
  localparam logic [KindW-1:0] KindDone      = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [UnitW-1:0]  unit;
    logic [BlockW-1:0] block;
    logic [SlotW-1:0]  slot;
    logic [MaskW-1:0]  write_ok_mask;
    logic              read_ok;
  } req_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [SlotW-1:0]  slot_used;
    logic [UnitW-1:0]  unit_out;
    logic [BlockW-1:0] block_out;
    logic              hit;
    logic              ok;
    logic              last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, reset position
    logic step;      // advance position
    logic apply;     // apply current action at position
    logic to_front;  // move slot at position to front, reset position
    logic emit;      // load output register
    logic hit;       // lookup found the block
    logic [1:0] sel; // 0 writeback, 1 read, 2 done
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic match;     // current slot matches (lookup hit / flush select)
    logic wb_need;   // current slot valid and dirty
    logic wb_ok;     // writeback of current slot succeeds
    logic rd_ok;     // miss fill read succeeds
    logic at_end;    // position at last entry
    logic out_busy;  // output register holds a transaction
  } sts_t;

endpackage

// ===== hdl/lbbc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU block buffer cache datapath
// Slot tags, flags, recency order, walk position and output register.
// ----------------------------------------------------------------------------
module lbbc_datapath import lbbc_pkg::*; #(
  parameter int unsigned NumSlots = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  input  logic ok_fail_i,
  output sts_t sts_o,
  output logic [OpW-1:0] op_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output rsp_t out_o
);

  localparam int unsigned IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  logic [NumSlots-1:0]           valid_q, dirty_q;
  logic [NumSlots-1:0][UnitW-1:0]  unit_q;
  logic [NumSlots-1:0][BlockW-1:0] blk_q;
  logic [NumSlots-1:0][IdxW-1:0]   ord_q;
  logic [IdxW-1:0] pos_q;
  req_t req_q;
  logic out_valid_q;
  rsp_t out_q;

  logic [IdxW-1:0] cur;
  logic [SlotW-1:0] cur_s;
  logic mark_in;

  assign cur   = ord_q[pos_q];
  assign cur_s = SlotW'(cur);
  assign op_o  = req_q.operation;
  assign mark_in = ({{(32-SlotW){1'b0}}, req_q.slot} < NumSlots);

  always_comb begin
    sts_o = '0;
    sts_o.wb_need = valid_q[cur] & dirty_q[cur];
    sts_o.wb_ok   = req_q.write_ok_mask[cur_s];
    sts_o.rd_ok   = req_q.read_ok;
    sts_o.at_end  = (pos_q == IdxW'(NumSlots - 1));
    sts_o.out_busy = out_valid_q;
    unique case (req_q.operation)
      OpLookup:    sts_o.match = valid_q[cur] && unit_q[cur] == req_q.unit
                                 && blk_q[cur] == req_q.block;
      OpFlushUnit: sts_o.match = (unit_q[cur] == req_q.unit);
      default:     sts_o.match = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      unit_q  <= '0;
      blk_q   <= '0;
      for (int i = 0; i < NumSlots; i++) ord_q[i] <= IdxW'(i);
      pos_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.load) begin
        req_q <= req_i;
        pos_q <= '0;
        if (req_i.operation == OpInvalidate) begin
          for (int i = 0; i < NumSlots; i++)
            if (unit_q[i] == req_i.unit) valid_q[i] <= 1'b0;
        end
        if (req_i.operation == OpMarkDirty &&
            {{(32-SlotW){1'b0}}, req_i.slot} < NumSlots)
          dirty_q[IdxW'(req_i.slot)] <= 1'b1;
      end
      if (cmd_i.step) pos_q <= pos_q + 1'b1;
      if (cmd_i.to_front) begin
        for (int i = 1; i < NumSlots; i++)
          if (IdxW'(i) <= pos_q) ord_q[i] <= ord_q[i-1];
        ord_q[0] <= cur;
        pos_q <= '0;
      end
      if (cmd_i.apply) begin
        unique case (cmd_i.sel)
          KindWriteback: begin
            dirty_q[cur] <= 1'b0;
            if ((sts_o.wb_need && !sts_o.wb_ok) ||
                req_q.operation == OpFlushAll) valid_q[cur] <= 1'b0;
          end
          KindRead: begin
            valid_q[ord_q[0]] <= req_q.read_ok;
            dirty_q[ord_q[0]] <= 1'b0;
            unit_q[ord_q[0]]  <= req_q.unit;
            blk_q[ord_q[0]]   <= req_q.block;
          end
          default: ;
        endcase
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        out_q <= '0;
        unique case (cmd_i.sel)
          KindWriteback: begin
            out_q.kind      <= KindWriteback;
            out_q.slot_used <= cur_s;
            out_q.unit_out  <= unit_q[cur];
            out_q.block_out <= blk_q[cur];
            out_q.ok        <= sts_o.wb_ok;
          end
          KindRead: begin
            out_q.kind      <= KindRead;
            out_q.slot_used <= SlotW'(ord_q[0]);
            out_q.unit_out  <= req_q.unit;
            out_q.block_out <= req_q.block;
            out_q.ok        <= req_q.read_ok;
          end
          default: begin
            out_q.kind <= KindDone;
            out_q.last <= 1'b1;
            unique case (req_q.operation)
              OpLookup: begin
                out_q.slot_used <= SlotW'(ord_q[0]);
                out_q.unit_out  <= req_q.unit;
                out_q.block_out <= req_q.block;
                out_q.hit       <= cmd_i.hit;
                out_q.ok        <= ~ok_fail_i;
              end
              OpMarkDirty: begin
                out_q.slot_used <= req_q.slot;
                out_q.ok        <= mark_in;
                if (mark_in) begin
                  out_q.unit_out  <= unit_q[IdxW'(req_q.slot)];
                  out_q.block_out <= blk_q[IdxW'(req_q.slot)];
                end
              end
              OpInvalidate: begin
                out_q.unit_out <= req_q.unit;
                out_q.ok       <= 1'b1;
              end
              OpFlushUnit: begin
                out_q.unit_out <= req_q.unit;
                out_q.ok       <= ~ok_fail_i;
              end
              OpFlushAll: out_q.ok <= ~ok_fail_i;
              default: ;
            endcase
          end
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  a_front_on_emit_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.to_front |=> (ord_q[0] == $past(cur)))
    else $error("recency front not updated");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !sts_o.at_end)
    else $error("walk position overflow");
`endif

endmodule

// ===== hdl/lbbc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU block buffer cache controller
// Sequences lookup, miss fill and flush walks one slot per unstalled cycle.
// ----------------------------------------------------------------------------
module lbbc_ctrl import lbbc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [OpW-1:0] op_i,
  input  sts_t sts_i,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  output logic fail_o
);

  typedef enum logic [2:0] {
    StIdle, StSearch, StVictim, StRead, StFlush, StDone
  } state_e;

  state_e state_q, state_d;
  logic fail_q, fail_d;
  logic hit_q, hit_d;
  logic free;

  assign free = !sts_i.out_busy || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign fail_o = fail_q;

  always_comb begin
    state_d = state_q;
    fail_d  = fail_q;
    hit_d   = hit_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        fail_d = 1'b0;
        hit_d  = 1'b0;
        state_d = StSearch;
      end
      StSearch: begin
        priority case (op_i)
          OpLookup: begin
            if (sts_i.match) begin
              cmd_o.to_front = 1'b1;
              hit_d = 1'b1;
              state_d = StDone;
            end else if (sts_i.at_end) begin
              cmd_o.to_front = 1'b1;
              state_d = StVictim;
            end else cmd_o.step = 1'b1;
          end
          OpFlushUnit, OpFlushAll: state_d = StFlush;
          default: state_d = StDone;
        endcase
      end
      StFlush: begin
        if (sts_i.match && sts_i.wb_need) begin
          if (free) begin
            cmd_o.emit = 1'b1;
            cmd_o.apply = 1'b1;
            if (!sts_i.wb_ok) fail_d = 1'b1;
            if (sts_i.at_end) state_d = StDone; else cmd_o.step = 1'b1;
          end
        end else begin
          cmd_o.apply = sts_i.match;
          if (sts_i.at_end) state_d = StDone; else cmd_o.step = 1'b1;
        end
      end
      StVictim: begin
        // position reset to zero so cur is the victim at the front
        if (sts_i.wb_need) begin
          if (free) begin
            cmd_o.emit = 1'b1;
            cmd_o.apply = 1'b1;
            if (!sts_i.wb_ok) begin
              fail_d = 1'b1;
              state_d = StDone;
            end else state_d = StRead;
          end
        end else begin
          cmd_o.apply = 1'b1;
          state_d = StRead;
        end
      end
      StRead: if (free) begin
        cmd_o.sel = KindRead;
        cmd_o.emit = 1'b1;
        cmd_o.apply = 1'b1;
        fail_d = ~sts_i.rd_ok;
        state_d = StDone;
      end
      StDone: if (free) begin
        cmd_o.sel = KindDone;
        cmd_o.hit = hit_q;
        cmd_o.emit = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fail_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fail_q  <= fail_d;
      hit_q   <= hit_d;
    end
  end

`ifndef SYNTH
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == StSearch)
    else $error("load without search");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && cmd_o.sel == KindDone) |=> in_ready_o)
    else $error("done without idle");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == StIdle)
    else $error("load while busy");
`endif

endmodule

// ===== hdl/lru_block_buffer_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU block buffer cache
// Fully associative write-back buffer cache tag store with move-to-front LRU.
// ----------------------------------------------------------------------------
//  channel | signals                       | payload
//  in      | in_valid_i / in_ready_o       | req_t  in_data_i
//  out     | out_valid_o / out_ready_i     | rsp_t  out_data_o
//
//  A lookup searches the recency order from the front to a hit or the end;
//  a miss writes back a dirty victim, then reads if that writeback succeeds.
//  Flushes walk every slot; other operations emit only their done result.
//  The next transaction can be accepted once the last result is loaded.
//  Reset clears all flags and tags and restores identity recency order.
//  A stalled output holds the walk at the next transaction.
// ----------------------------------------------------------------------------
module lru_block_buffer_cache import lbbc_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  cmd_t cmd;
  sts_t sts;
  logic fail;
  logic [OpW-1:0] op;

  lbbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .op_i(op), .sts_i(sts), .out_ready_i, .cmd_o(cmd), .fail_o(fail)
  );

  lbbc_datapath #(.NumSlots(NUM_SLOTS)) u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .ok_fail_i(fail),
    .sts_o(sts), .op_o(op), .out_ready_i, .out_valid_o, .out_o(out_data_o)
  );

endmodule
